[design/amc_pkg.sv]
package amc_pkg;

  localparam logic [1:0] OP_MESSAGE = 2'd0;
  localparam logic [1:0] OP_POLL    = 2'd1;
  localparam logic [1:0] OP_OPEN    = 2'd2;
  localparam logic [1:0] OP_CLOSE   = 2'd3;

  localparam logic [1:0] REASON_NONE  = 2'd0;
  localparam logic [1:0] REASON_COUNT = 2'd1;
  localparam logic [1:0] REASON_TIME  = 2'd2;

  localparam int PADDR_W = 3;
  localparam logic REG_START_BATCH_LIMIT = 1'b0;
  localparam logic [5:0] START_LIMIT_RESET = 6'd1;

  typedef struct packed {
    logic [1:0]  op;
    logic [9:0]  tunnel_id;
    logic [31:0] now_sec;
    logic [9:0]  now_msec;
  } req_t;

  typedef struct packed {
    logic        accepted;
    logic [4:0]  write_slot;
    logic        flush;
    logic [1:0]  flush_reason;
    logic [5:0]  flush_count;
    logic [9:0]  tunnel_out;
  } rsp_t;

endpackage

[design/amc_ram.sv]
module amc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[design/adaptive_message_coalescer_top.sv]
// flow: an accepted request is registered together with its table read (S_EXEC), then the
// entry is modified and written back and the result is registered; busy blocks new items meanwhile
// the receiver cannot stall; each result beat shows for exactly one cycle
// reset: synchronous; the tunnel table is then cleared one entry per cycle,
// with busy high; configuration writes are taken meanwhile
module adaptive_message_coalescer_top #(
  parameter int NUM_TUNNELS = 1024,
  parameter int MAX_BATCH   = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  amc_pkg::req_t                req,
  output logic                         rsp_valid,
  output amc_pkg::rsp_t                rsp,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [amc_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  localparam int AW = $clog2(NUM_TUNNELS);
  localparam int CW = $clog2(MAX_BATCH + 1);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_EXEC  = 2'd2;

  typedef struct packed {
    logic          valid;
    logic [CW-1:0] count;
    logic [31:0]   sec;
    logic [9:0]    msec;
  } entry_t;

  localparam int EW = $bits(entry_t);

  logic [1:0]          state;
  logic [1:0]          state_next;
  logic [AW-1:0]       clr_addr;
  amc_pkg::req_t       req_q;
  logic [5:0]          start_limit;
  logic [CW-1:0]       batch_limit;
  logic [CW-1:0]       batch_limit_next;
  logic [CW-1:0]       cfg_limit;

  logic                take;
  logic                cfg_wr;
  logic [16:0]         tid_ext_in;
  logic [16:0]         tid_ext_q;
  logic                in_range;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [EW-1:0]       ram_wdata;
  logic [EW-1:0]       ram_rdata;

  entry_t              cur;
  entry_t              upd;
  logic                upd_we;
  logic [CW-1:0]       n;
  logic [31:0]         n_ext;
  logic [31:0]         slot_ext;
  amc_pkg::rsp_t       rsp_next;

  assign take       = start && !busy;
  assign busy       = (state != S_IDLE);
  assign pready     = 1'b1;
  assign cfg_wr     = psel && penable && pwrite && pready;
  assign tid_ext_in = {7'b0, req.tunnel_id};
  assign tid_ext_q  = {7'b0, req_q.tunnel_id};
  assign in_range   = tid_ext_q < 17'(NUM_TUNNELS);
  assign cur        = entry_t'(ram_rdata);

  // clamp of the written start limit to 1..MAX_BATCH for batch_limit; start_limit keeps the raw value
  always_comb begin
    if (pwdata[5:0] == 6'd0) begin
      cfg_limit = CW'(1);
    end else if (32'(pwdata[5:0]) > 32'(MAX_BATCH)) begin
      cfg_limit = CW'(MAX_BATCH);
    end else begin
      cfg_limit = CW'(pwdata[5:0]);
    end
  end

  always_comb begin
    if (paddr[2] == amc_pkg::REG_START_BATCH_LIMIT) begin
      prdata = {26'b0, start_limit};
    end else begin
      prdata = 32'b0;
    end
  end

  // read-modify-write of one tunnel entry
  always_comb begin
    upd              = cur;
    upd_we           = 1'b0;
    batch_limit_next = batch_limit;
    n                = cur.count;
    rsp_next         = '0;
    rsp_next.tunnel_out = req_q.tunnel_id;
    if (req_q.op == amc_pkg::OP_MESSAGE) begin
      n = cur.count + CW'(1);
    end
    n_ext    = 32'(n);
    slot_ext = 32'(cur.count);
    if (in_range) begin
      unique case (req_q.op)
        amc_pkg::OP_OPEN: begin
          upd_we = 1'b1;
          upd    = '0;
          upd.valid = 1'b1;
          rsp_next.accepted = 1'b1;
        end
        amc_pkg::OP_CLOSE: begin
          upd_we = 1'b1;
          upd    = '0;
          rsp_next.accepted = cur.valid;
        end
        amc_pkg::OP_MESSAGE, amc_pkg::OP_POLL: begin
          if (cur.valid) begin
            rsp_next.accepted = 1'b1;
            if (req_q.op == amc_pkg::OP_MESSAGE) begin
              rsp_next.write_slot = slot_ext[4:0];
            end
            if (req_q.op == amc_pkg::OP_MESSAGE || cur.count != '0) begin
              upd_we    = 1'b1;
              upd.count = n;
              upd.sec   = req_q.now_sec;
              upd.msec  = req_q.now_msec;
              if (n >= batch_limit) begin
                rsp_next.flush_reason = amc_pkg::REASON_COUNT;
              end else if (cur.sec < req_q.now_sec) begin
                rsp_next.flush_reason = amc_pkg::REASON_TIME;
              end else if (cur.sec == req_q.now_sec && cur.msec != req_q.now_msec) begin
                rsp_next.flush_reason = amc_pkg::REASON_TIME;
              end
              if (rsp_next.flush_reason != amc_pkg::REASON_NONE) begin
                rsp_next.flush       = 1'b1;
                rsp_next.flush_count = n_ext[5:0];
                upd.count            = '0;
              end
              if (rsp_next.flush_reason == amc_pkg::REASON_COUNT) begin
                if (batch_limit < CW'(MAX_BATCH)) begin
                  batch_limit_next = batch_limit + CW'(1);
                end
              end else if (rsp_next.flush_reason == amc_pkg::REASON_TIME) begin
                if (batch_limit > CW'(1)) begin
                  batch_limit_next = batch_limit - CW'(1);
                end
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = tid_ext_q[AW-1:0];
    ram_wdata = EW'(upd);
    unique case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = '0;
      end
      S_EXEC: begin
        ram_we = upd_we;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (clr_addr == AW'(NUM_TUNNELS - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (take) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  amc_ram #(
    .WIDTH(EW),
    .DEPTH(NUM_TUNNELS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (take),
    .raddr (tid_ext_in[AW-1:0]),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      clr_addr    <= '0;
      rsp_valid   <= 1'b0;
      start_limit <= amc_pkg::START_LIMIT_RESET;
      batch_limit <= CW'(1);
    end else begin
      state     <= state_next;
      rsp_valid <= (state == S_EXEC);
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end
      if (cfg_wr && paddr[2] == amc_pkg::REG_START_BATCH_LIMIT) begin
        start_limit <= pwdata[5:0];
        batch_limit <= cfg_limit;
      end else if (state == S_EXEC) begin
        batch_limit <= batch_limit_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      req_q <= req;
    end
    if (state == S_EXEC) begin
      rsp <= rsp_next;
    end
  end

endmodule
